// File: design/ppu_pkg.sv
// Shared types and constants for the perspective projection unit.
// No dependencies.
`timescale 1ns / 1ps
package ppu_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned DimW = 14;
  localparam int unsigned NumW = 61;
  localparam int unsigned DivSteps = 61;
  localparam logic signed [31:0] WThresh = 32'sd65;
  localparam logic [DimW-1:0] WidthReset = 14'd1920;
  localparam logic [DimW-1:0] HeightReset = 14'd1080;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_ACC, OP_CLIP, OP_HMUL, OP_HACC, OP_DIVINIT, OP_DIVSTEP,
    OP_DIVFIN, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] row;
    logic [1:0] col;
    logic       axis;
  } dp_cmd_t;

  typedef struct packed {
    logic in_front;
  } dp_status_t;
endpackage

// File: design/ppu_datapath.sv
// Datapath: coefficient store, shared multiplier, accumulator, serial divider.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_datapath import ppu_pkg::*; (
  input  logic                     clk,
  input  dp_cmd_t                  cmd,
  input  logic                     load_en,
  input  logic [3:0]               coef_index,
  input  logic signed [CoordW-1:0] coef_value,
  input  logic signed [CoordW-1:0] pos_x,
  input  logic signed [CoordW-1:0] pos_y,
  input  logic signed [CoordW-1:0] pos_z,
  input  logic                     rst,
  input  logic [DimW-1:0]          view_width,
  input  logic [DimW-1:0]          view_height,
  output dp_status_t               status,
  output logic signed [CoordW-1:0] screen_x,
  output logic signed [CoordW-1:0] screen_y,
  output logic                     in_front
);
  logic signed [CoordW-1:0] view_matrix [16];
  logic signed [CoordW-1:0] px, py, pz;
  logic signed [63:0]       prod;
  logic signed [49:0]       acc;
  logic signed [CoordW-1:0] cx, cy, cw;
  logic signed [63:0]       num;
  logic [NumW-1:0]          quo;
  logic [CoordW-1:0]        rem;
  logic [CoordW-1:0]        dvs;
  logic                     neg;
  logic signed [31:0]       half;
  logic                     front;

  logic signed [CoordW-1:0] mul_a, mul_b, csel;
  logic [CoordW:0]          trial;
  logic [CoordW:0]          rem_sh;
  logic signed [49:0]       acc_sum;
  logic signed [49:0]       sat_in;
  logic signed [CoordW-1:0] sat_out;
  logic [NumW-1:0]          num_mag;
  logic signed [63:0]       qs;
  logic signed [63:0]       res;
  logic signed [CoordW-1:0] res_sat;

  always_comb begin
    mul_b = view_matrix[{cmd.row, cmd.col}];
    case (cmd.row)
      2'd0: mul_a = px;
      2'd1: mul_a = py;
      default: mul_a = pz;
    endcase
    csel = cmd.axis ? cy : cx;
    acc_sum = acc + 50'(prod >>> 16);
    sat_in = acc + 50'(view_matrix[{2'd3, cmd.col}]);
    if (sat_in > 50'sh7FFFFFFF) sat_out = 32'sh7FFFFFFF;
    else if (sat_in < -50'sh80000000) sat_out = 32'sh80000000;
    else sat_out = sat_in[31:0];
    num_mag = num[63] ? NumW'(-num) : NumW'(num);
    rem_sh = {rem, quo[NumW-1]};
    trial = rem_sh - {1'b0, dvs};
    qs = neg ? -$signed({3'b000, quo}) : $signed({3'b000, quo});
    res = cmd.axis ? 64'(half) - qs : 64'(half) + qs;
    if (res > 64'sh7FFFFFFF) res_sat = 32'sh7FFFFFFF;
    else if (res < -64'sh80000000) res_sat = 32'sh80000000;
    else res_sat = res[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) view_matrix[i] <= '0;
    end else if (load_en) begin
      view_matrix[coef_index] <= coef_value;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        px <= pos_x;
        py <= pos_y;
        pz <= pos_z;
        acc <= '0;
      end
      OP_MUL: prod <= 64'(mul_a) * 64'(mul_b);
      OP_ACC: acc <= acc_sum;
      OP_CLIP: begin
        case (cmd.col)
          2'd0: cx <= sat_out;
          2'd1: cy <= sat_out;
          default: begin
            cw <= sat_out;
            front <= sat_out > WThresh;
          end
        endcase
        acc <= '0;
      end
      OP_HMUL: begin
        half <= cmd.axis ? 32'({view_height, 15'd0}) : 32'({view_width, 15'd0});
        prod <= 64'(csel) * 64'(signed'({1'b0, cmd.axis ? view_height : view_width}));
      end
      // half * c = size * c * 2^15
      OP_HACC: num <= prod <<< 15;
      OP_DIVINIT: begin
        neg <= num[63];
        quo <= num_mag;
        rem <= '0;
        dvs <= cw;
      end
      OP_DIVSTEP: begin
        if (!trial[CoordW]) begin
          rem <= trial[CoordW-1:0];
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[CoordW-1:0];
          quo <= {quo[NumW-2:0], 1'b0};
        end
      end
      OP_DIVFIN: begin
        if (cmd.axis) screen_y <= front ? res_sat : '0;
        else screen_x <= front ? res_sat : '0;
      end
      default: ;
    endcase
  end

  assign in_front = front;
  assign status.in_front = front;
endmodule

// File: design/ppu_ctrl.sv
// Controller state machine sequencing the projection datapath.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_ctrl import ppu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       func,
  input  dp_status_t status,
  output logic       busy,
  output logic       load_en,
  output dp_cmd_t    cmd,
  output logic       done
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_CLIP, S_HMUL, S_HACC, S_DINIT, S_DSTEP, S_DFIN, S_DONE
  } state_t;

  state_t     state;
  logic [1:0] row, col;
  logic       axis;
  logic [5:0] cnt;

  assign load_en = start && !busy && !func;

  always_comb begin
    cmd.row = row;
    cmd.col = col;
    cmd.axis = axis;
    case (state)
      S_IDLE:  cmd.op = (start && func) ? OP_LOAD : OP_NONE;
      S_MUL:   cmd.op = OP_MUL;
      S_ACC:   cmd.op = OP_ACC;
      S_CLIP:  cmd.op = OP_CLIP;
      S_HMUL:  cmd.op = OP_HMUL;
      S_HACC:  cmd.op = OP_HACC;
      S_DINIT: cmd.op = OP_DIVINIT;
      S_DSTEP: cmd.op = OP_DIVSTEP;
      S_DFIN:  cmd.op = OP_DIVFIN;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      row <= '0;
      col <= '0;
      axis <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start && func) begin
          state <= S_MUL;
          busy <= 1'b1;
          row <= '0;
          col <= '0;
          axis <= 1'b0;
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (row == 2'd2) state <= S_CLIP;
          else begin
            row <= row + 2'd1;
            state <= S_MUL;
          end
        end
        S_CLIP: begin
          row <= '0;
          if (col == 2'd3) state <= S_HMUL;
          else begin
            // skip column two, z is not used
            col <= (col == 2'd1) ? 2'd3 : col + 2'd1;
            state <= S_MUL;
          end
        end
        S_HMUL: state <= status.in_front ? S_HACC : S_DFIN;
        S_HACC: state <= S_DINIT;
        S_DINIT: begin
          cnt <= 6'(DivSteps - 1);
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          if (cnt == '0) state <= S_DFIN;
          else cnt <= cnt - 6'd1;
        end
        S_DFIN: begin
          if (axis) state <= S_DONE;
          else begin
            axis <= 1'b1;
            state <= S_HMUL;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/perspective_projection_unit.sv
// Perspective projection unit: a project item is computed as multiply-accumulate steps
// for clip x, y and w, then two passes (x, then y) of scaling and a 61-step serial
// division by w; the result is transferred with a one-cycle strobe.
// A point behind the camera skips the divisions and returns sooner.
// Busy drops with the strobe; a new project item is taken only while busy is low. Loads do not raise busy.
// The receiver cannot stall. Reset clears the matrix and sets the viewport to 1920 x 1080.
`timescale 1ns / 1ps
module perspective_projection_unit import ppu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               strobe,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               in_front,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [DimW-1:0] view_width, view_height;
  dp_cmd_t         cmd;
  dp_status_t      status;
  logic            load_en;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width <= WidthReset;
      view_height <= HeightReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) view_width <= pwdata[DimW-1:0];
      else if (paddr == 3'd4) view_height <= pwdata[DimW-1:0];
    end
  end

  always_comb begin
    if (paddr == 3'd0) prdata = {18'd0, view_width};
    else if (paddr == 3'd4) prdata = {18'd0, view_height};
    else prdata = '0;
  end

  ppu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(func), .status(status),
    .busy(busy), .load_en(load_en), .cmd(cmd), .done(strobe)
  );

  ppu_datapath u_dp (
    .clk(clk), .cmd(cmd), .load_en(load_en), .coef_index(coef_index),
    .coef_value(coef_value), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .rst(rst), .view_width(view_width), .view_height(view_height),
    .status(status), .screen_x(screen_x), .screen_y(screen_y), .in_front(in_front)
  );
endmodule

// File: design/ppu_checker.sv
// Port-level checker for the perspective projection unit, bound to the top.
// Depends on nothing beyond the top level's ports.
`timescale 1ns / 1ps
module ppu_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        func,
  input logic        strobe,
  input logic        in_front,
  input logic [31:0] screen_x,
  input logic [31:0] screen_y
);
  a_idle_strobe: assert property (@(posedge clk) disable iff (rst) strobe |-> !busy)
    else $error("strobe while busy");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !func |=> !busy && !strobe) else $error("load started work");
  a_proj_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func |=> busy) else $error("project not taken");
  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !in_front |-> screen_x == 32'd0 && screen_y == 32'd0)
    else $error("behind point not zero");
  a_one_strobe: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("double strobe");
endmodule

bind perspective_projection_unit ppu_checker u_ppu_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .strobe(strobe),
  .in_front(in_front), .screen_x(screen_x), .screen_y(screen_y)
);
